>>> design/ray_sphere_intersect_top_defines.svh
// assertion helpers used by the top-level design file
`ifndef RAY_SPHERE_INTERSECT_TOP_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_TOP_DEFINES_SVH

// same-cycle implication, off while reset is low
`define RSI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is low
`define RSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/rsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rsi_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int OUT_W = 31;
	localparam int WIDE_W = 64;
	localparam int RAD_W = 128;
	localparam int NUM_W = 66;
	localparam logic [62:0] CLAMP62 = 63'h4000_0000_0000_0000;
	localparam logic [OUT_W-1:0] MAX31 = '1;

	typedef struct packed {
		logic away;
		logic azero;
		logic cneg;
		logic [WIDE_W-1:0] pmag;
		logic [WIDE_W-1:0] asum;
		logic [WIDE_W-1:0] cmag;
		logic [OUT_W-1:0] radius;
	} sq_side_t;

	typedef struct packed {
		logic hit;
		logic qzero;
	} dv_side_t;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
		logic signed [31:0] r;
		if (x[32] != x[31]) begin
			r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

>>> design/rsi_mul64.sv
`timescale 1ns / 1ps
`default_nettype none
module rsi_mul64 (
	input  logic                            clk,
	input  logic [rsi_pkg::WIDE_W-1:0]      a,
	input  logic [rsi_pkg::WIDE_W-1:0]      b,
	output logic [2*rsi_pkg::WIDE_W-1:0]    p
);
	localparam int HW = rsi_pkg::WIDE_W / 2;
	localparam int PW = 2 * rsi_pkg::WIDE_W;

	logic [rsi_pkg::WIDE_W-1:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [PW-1:0] p_s2;

	// four half-width partial products are registered, then summed into the registered product p_s2
	always_ff @(posedge clk) begin
		ll_s1 <= a[HW-1:0] * b[HW-1:0];
		lh_s1 <= a[HW-1:0] * b[2*HW-1:HW];
		hl_s1 <= a[2*HW-1:HW] * b[HW-1:0];
		hh_s1 <= a[2*HW-1:HW] * b[2*HW-1:HW];
		p_s2 <= {hh_s1, {2*HW{1'b0}}} + {{HW{1'b0}}, lh_s1, {HW{1'b0}}}
			+ {{HW{1'b0}}, hl_s1, {HW{1'b0}}} + {{2*HW{1'b0}}, ll_s1};
	end

	assign p = p_s2;
endmodule
`default_nettype wire

>>> design/rsi_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module rsi_sqrt #(
	parameter int W  = rsi_pkg::RAD_W,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [W-1:0]    rad,
	input  logic [SW-1:0]   side_in,
	output logic            out_valid,
	output logic [W/2-1:0]  root,
	output logic [SW-1:0]   side_out
);
	localparam int RW = W / 2;

	logic [RW+1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [W-1:0]  rad_s  [RW];
	logic [SW-1:0] side_s [RW];
	logic          vld_s  [RW];

	logic [RW+1:0] crem  [RW];
	logic [RW-1:0] croot [RW];
	logic [W-1:0]  crad  [RW];
	logic [RW+2:0] tmp   [RW];
	logic [RW+2:0] trial [RW];
	logic          ge    [RW];
	logic [RW+2:0] diff  [RW];

	// one result bit per stage, restoring digit-by-digit method
	always_comb begin
		crem[0] = '0;
		croot[0] = '0;
		crad[0] = rad;
		for (int k = 1; k < RW; k++) begin
			crem[k] = rem_s[k-1];
			croot[k] = root_s[k-1];
			crad[k] = rad_s[k-1];
		end
		for (int k = 0; k < RW; k++) begin
			tmp[k] = {crem[k][RW:0], crad[k][W-1:W-2]};
			trial[k] = {1'b0, croot[k], 2'b01};
			ge[k] = tmp[k] >= trial[k];
			diff[k] = tmp[k] - trial[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RW; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < RW; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side_in;
		for (int k = 1; k < RW; k++) begin
			side_s[k] <= side_s[k-1];
		end
		for (int k = 0; k < RW; k++) begin
			rem_s[k] <= ge[k] ? diff[k][RW+1:0] : tmp[k][RW+1:0];
			root_s[k] <= {croot[k][RW-2:0], ge[k]};
			rad_s[k] <= {crad[k][W-3:0], 2'b00};
		end
	end

	assign out_valid = vld_s[RW-1];
	assign root = root_s[RW-1];
	assign side_out = side_s[RW-1];
endmodule
`default_nettype wire

>>> design/rsi_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rsi_div #(
	parameter int NW        = rsi_pkg::NUM_W,
	parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF,
	parameter int SW        = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [NW-1:0]               num,
	input  logic [NW-1:0]               den,
	input  logic [SW-1:0]               side_in,
	output logic                        out_valid,
	output logic [rsi_pkg::OUT_W-1:0]   quo,
	output logic [SW-1:0]               side_out
);
	localparam int QW = rsi_pkg::OUT_W;
	localparam int SH = QW - FRAC_BITS;

	// quotient of num * 2^FRAC_BITS / den, saturated to QW bits
	logic [NW-1:0] rem_s  [QW+1];
	logic [QW-1:0] lo_s   [QW+1];
	logic [NW-1:0] den_s  [QW+1];
	logic [QW-1:0] q_s    [QW+1];
	logic          sat_s  [QW+1];
	logic [SW-1:0] side_s [QW+1];
	logic          vld_s  [QW+1];

	logic [NW-1:0] hi;
	logic [NW:0]   trial [QW];
	logic          ge    [QW];
	logic [NW:0]   diff  [QW];

	always_comb begin
		hi = num >> SH;
		for (int k = 0; k < QW; k++) begin
			trial[k] = {rem_s[k], lo_s[k][QW-1]};
			ge[k] = trial[k] >= {1'b0, den_s[k]};
			diff[k] = trial[k] - {1'b0, den_s[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[0] <= in_valid;
			for (int k = 0; k < QW; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		// a quotient of QW+1 bits or more shows up in the top bits alone
		sat_s[0] <= hi >= den;
		rem_s[0] <= hi;
		lo_s[0] <= {num[SH-1:0], {FRAC_BITS{1'b0}}};
		den_s[0] <= den;
		q_s[0] <= '0;
		side_s[0] <= side_in;
		for (int k = 0; k < QW; k++) begin
			rem_s[k+1] <= ge[k] ? diff[k][NW-1:0] : trial[k][NW-1:0];
			lo_s[k+1] <= {lo_s[k][QW-2:0], 1'b0};
			den_s[k+1] <= den_s[k];
			q_s[k+1] <= {q_s[k][QW-2:0], ge[k]};
			sat_s[k+1] <= sat_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = vld_s[QW];
	assign quo = sat_s[QW] ? rsi_pkg::MAX31 : q_s[QW];
	assign side_out = side_s[QW];
endmodule
`default_nettype wire

>>> design/ray_sphere_intersect_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Ray against sphere test, fully pipelined, coordinates in signed fixed point.
// Command channel: a transaction is taken at each rising edge where start is
// high and busy is low. busy is held low, so one ray may be issued every cycle.
// Result channel: done is high for exactly one cycle with hit, hit_distance and
// offset_ratio; the receiver takes it in that cycle and cannot hold it off.
// Results leave in command order, one per cycle at most. Throughput: one ray
// per cycle. The pipeline is made of nine front stages of products and sums,
// two 64-stage square-root pipelines (one result bit per stage), a register,
// two 32-stage restoring dividers (an input stage, then one quotient bit per
// stage) and the output register.
// Reset (arst_n low) clears every valid bit at once, so work in flight is
// dropped and no done pulse follows for it; the block takes commands in the
// first cycle after reset is released.
`include "ray_sphere_intersect_top_defines.svh"
module ray_sphere_intersect_top #(
	parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  origin_x,
	input  logic signed [31:0]  origin_y,
	input  logic signed [31:0]  origin_z,
	input  logic signed [31:0]  dir_x,
	input  logic signed [31:0]  dir_y,
	input  logic signed [31:0]  dir_z,
	input  logic signed [31:0]  center_x,
	input  logic signed [31:0]  center_y,
	input  logic signed [31:0]  center_z,
	input  logic [30:0]         sphere_radius,
	output logic                done,
	output logic                hit,
	output logic [30:0]         hit_distance,
	output logic [30:0]         offset_ratio
);
	localparam int WW = rsi_pkg::WIDE_W;
	localparam int NW = rsi_pkg::NUM_W;
	localparam int RDW = rsi_pkg::RAD_W;
	localparam int OW = rsi_pkg::OUT_W;
	localparam int SQ_LAT = RDW / 2;
	localparam int DV_LAT = OW + 1;
	localparam int LAT = 9 + SQ_LAT + 1 + DV_LAT + 1;
	localparam int SQ_SW = $bits(rsi_pkg::sq_side_t);
	localparam int DV_SW = $bits(rsi_pkg::dv_side_t);

	logic take;
	logic signed [31:0] org [3];
	logic signed [31:0] ctr [3];
	logic signed [31:0] dv  [3];

	assign busy = 1'b0;
	assign take = start && !busy;
	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign ctr[0] = center_x;
	assign ctr[1] = center_y;
	assign ctr[2] = center_z;
	assign dv[0] = dir_x;
	assign dv[1] = dir_y;
	assign dv[2] = dir_z;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s74;

	// stage 1: offset from center, saturated
	logic signed [31:0] l_s1 [3];
	logic signed [31:0] d_s1 [3];
	logic [OW-1:0] r_s1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			l_s1[i] <= rsi_pkg::sat32({org[i][31], org[i]} - {ctr[i][31], ctr[i]});
			d_s1[i] <= dv[i];
		end
		r_s1 <= sphere_radius;
	end

	// stage 2: products
	logic signed [63:0] pprod [3];
	logic signed [63:0] dprod [3];
	logic signed [63:0] lprod [3];
	logic [61:0] rprod;
	logic signed [63:0] p_s2 [3];
	logic [WW-1:0] dsq_s2 [3];
	logic [WW-1:0] lsq_s2 [3];
	logic [61:0] r2_s2;
	logic signed [31:0] l_s2 [3];
	logic signed [31:0] d_s2 [3];
	logic [OW-1:0] r_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pprod[i] = l_s1[i] * d_s1[i];
			dprod[i] = d_s1[i] * d_s1[i];
			lprod[i] = l_s1[i] * l_s1[i];
		end
		rprod = r_s1 * r_s1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p_s2[i] <= pprod[i];
			dsq_s2[i] <= dprod[i];
			lsq_s2[i] <= lprod[i];
			l_s2[i] <= l_s1[i];
			d_s2[i] <= d_s1[i];
		end
		r2_s2 <= rprod;
		r_s2 <= r_s1;
	end

	// stage 3: dot product and sums of squares
	logic signed [65:0] ldot;
	logic signed [65:0] nldot;
	logic [31:0] dabs [3];
	logic away_s3;
	logic [WW-1:0] pmag_s3, asum_s3, lsum_s3;
	logic [61:0] r2_s3;
	logic [31:0] dm_s3 [3];
	logic dpos_s3 [3];
	logic dngt_s3 [3];
	logic signed [31:0] l_s3 [3];
	logic [OW-1:0] r_s3;

	always_comb begin
		ldot = {{2{p_s2[0][63]}}, p_s2[0]} + {{2{p_s2[1][63]}}, p_s2[1]}
			+ {{2{p_s2[2][63]}}, p_s2[2]};
		nldot = -ldot;
		for (int i = 0; i < 3; i++) begin
			dabs[i] = d_s2[i][31] ? (~d_s2[i] + 32'd1) : d_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		away_s3 <= !ldot[65] && (ldot != '0);
		pmag_s3 <= nldot[WW-1:0];
		asum_s3 <= dsq_s2[0] + dsq_s2[1] + dsq_s2[2];
		lsum_s3 <= lsq_s2[0] + lsq_s2[1] + lsq_s2[2];
		r2_s3 <= r2_s2;
		r_s3 <= r_s2;
		for (int i = 0; i < 3; i++) begin
			dm_s3[i] <= dabs[i];
			dpos_s3[i] <= !d_s2[i][31] && (d_s2[i] != '0);
			dngt_s3[i] <= d_s2[i][31];
			l_s3[i] <= l_s2[i];
		end
	end

	// stage 4: c = L.L - r^2 and partial products of |Ldot| * |dir|
	logic cneg4;
	rsi_pkg::sq_side_t side_s4, side_s5, side_s6, side_s7, side_s8, side_s9;
	logic [WW-1:0] pplo_s4 [3];
	logic [WW-1:0] pphi_s4 [3];
	logic dpos_s4 [3];
	logic dngt_s4 [3];
	logic signed [31:0] l_s4 [3];

	assign cneg4 = lsum_s3 < {2'b00, r2_s3};

	always_ff @(posedge clk) begin
		side_s4.away <= away_s3;
		side_s4.azero <= asum_s3 == '0;
		side_s4.cneg <= cneg4;
		side_s4.pmag <= pmag_s3;
		side_s4.asum <= asum_s3;
		side_s4.cmag <= cneg4 ? ({2'b00, r2_s3} - lsum_s3) : (lsum_s3 - {2'b00, r2_s3});
		side_s4.radius <= r_s3;
		for (int i = 0; i < 3; i++) begin
			pplo_s4[i] <= pmag_s3[31:0] * dm_s3[i];
			pphi_s4[i] <= pmag_s3[63:32] * dm_s3[i];
			dpos_s4[i] <= dpos_s3[i];
			dngt_s4[i] <= dngt_s3[i];
			l_s4[i] <= l_s3[i];
		end
	end

	// Ldot^2 and a*c, ready at stage 6
	logic [2*WW-1:0] p2_s6, ac_s6;

	rsi_mul64 u_mul_p2 (
		.clk (clk),
		.a   (side_s4.pmag),
		.b   (side_s4.pmag),
		.p   (p2_s6)
	);

	rsi_mul64 u_mul_ac (
		.clk (clk),
		.a   (side_s4.asum),
		.b   (side_s4.cmag),
		.p   (ac_s6)
	);

	// stage 5: scaled projection, clamped
	logic [95:0] prod [3];
	logic [95:0] msh [3];
	logic [62:0] mv_s5 [3];
	logic dpos_s5 [3];
	logic dngt_s5 [3];
	logic signed [31:0] l_s5 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = {pphi_s4[i], 32'b0} + {32'b0, pplo_s4[i]};
			msh[i] = prod[i] >> (2 * FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		side_s5 <= side_s4;
		for (int i = 0; i < 3; i++) begin
			mv_s5[i] <= (msh[i] > {33'b0, rsi_pkg::CLAMP62}) ? rsi_pkg::CLAMP62 : msh[i][62:0];
			dpos_s5[i] <= dpos_s4[i];
			dngt_s5[i] <= dngt_s4[i];
			l_s5[i] <= l_s4[i];
		end
	end

	// stage 6: perpendicular component magnitude, clamped
	logic signed [64:0] lx [3];
	logic signed [64:0] mvx [3];
	logic signed [64:0] vs [3];
	logic signed [64:0] vneg [3];
	logic [64:0] vm [3];
	logic [WW-1:0] a_s6 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lx[i] = {{33{l_s5[i][31]}}, l_s5[i]};
			mvx[i] = {2'b00, mv_s5[i]};
			if (dpos_s5[i]) begin
				vs[i] = lx[i] + mvx[i];
			end else if (dngt_s5[i]) begin
				vs[i] = lx[i] - mvx[i];
			end else begin
				vs[i] = lx[i];
			end
			vneg[i] = -vs[i];
			vm[i] = vs[i][64] ? vneg[i] : vs[i];
		end
	end

	always_ff @(posedge clk) begin
		side_s6 <= side_s5;
		for (int i = 0; i < 3; i++) begin
			a_s6[i] <= (vm[i] > {2'b00, rsi_pkg::CLAMP62}) ? {1'b0, rsi_pkg::CLAMP62}
				: vm[i][WW-1:0];
		end
	end

	logic [2*WW-1:0] asq_s8 [3];

	for (genvar g = 0; g < 3; g++) begin : g_asq
		rsi_mul64 u_mul_asq (
			.clk (clk),
			.a   (a_s6[g]),
			.b   (a_s6[g]),
			.p   (asq_s8[g])
		);
	end

	// stages 7 to 9: discriminant, delayed to line up with the sum of |v|^2
	logic [2*WW:0] hdif;
	logic [2*WW-1:0] h_s7, h_s8, h_s9;
	logic dneg_s7, dneg_s8, dneg_s9;
	logic [2*WW-1:0] vsq_s9;

	assign hdif = {1'b0, p2_s6} - {1'b0, ac_s6};

	always_ff @(posedge clk) begin
		side_s7 <= side_s6;
		h_s7 <= side_s6.cneg ? (p2_s6 + ac_s6) : hdif[2*WW-1:0];
		dneg_s7 <= !side_s6.cneg && hdif[2*WW];
		side_s8 <= side_s7;
		h_s8 <= h_s7;
		dneg_s8 <= dneg_s7;
		side_s9 <= side_s8;
		h_s9 <= h_s8;
		dneg_s9 <= dneg_s8;
		vsq_s9 <= asq_s8[0] + asq_s8[1] + asq_s8[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// square roots of |v|^2 and the discriminant, in lockstep
	logic sq_v, sqh_v;
	logic [RDW/2-1:0] len_root, h_root;
	logic [SQ_SW-1:0] sq_side_vec;
	logic [0:0] dneg_sq;
	rsi_pkg::sq_side_t sqside;

	rsi_sqrt #(.W(RDW), .SW(SQ_SW)) u_sqrt_len (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s9),
		.rad       (vsq_s9),
		.side_in   (side_s9),
		.out_valid (sq_v),
		.root      (len_root),
		.side_out  (sq_side_vec)
	);

	rsi_sqrt #(.W(RDW), .SW(1)) u_sqrt_h (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s9),
		.rad       (h_s9),
		.side_in   (dneg_s9),
		.out_valid (sqh_v),
		.root      (h_root),
		.side_out  (dneg_sq)
	);

	assign sqside = rsi_pkg::sq_side_t'(sq_side_vec);

	// q = -Ldot + sqrt(disc), then pick the stable root form
	logic [NW-1:0] q;
	logic [NW-1:0] dnum_s74, dden_s74, onum_s74, oden_s74;
	rsi_pkg::dv_side_t dside_s74;
	logic away_s74;

	assign q = {2'b00, sqside.pmag} + {2'b00, h_root};

	always_ff @(posedge clk) begin
		dnum_s74 <= sqside.cneg ? q : {2'b00, sqside.cmag};
		dden_s74 <= sqside.cneg ? {2'b00, sqside.asum} : q;
		onum_s74 <= {2'b00, len_root};
		oden_s74 <= {{(NW-OW){1'b0}}, sqside.radius};
		dside_s74.hit <= !sqside.away && !sqside.azero && !dneg_sq[0];
		dside_s74.qzero <= !sqside.cneg && (q == '0);
		away_s74 <= sqside.away;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s74 <= 1'b0;
		end else begin
			v_s74 <= sq_v;
		end
	end

	logic dv_v, ov_v;
	logic [OW-1:0] dquo, oquo;
	logic [DV_SW-1:0] dside_vec;
	logic [0:0] oaway;
	rsi_pkg::dv_side_t dside;

	rsi_div #(.NW(NW), .FRAC_BITS(FRAC_BITS), .SW(DV_SW)) u_div_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s74),
		.num       (dnum_s74),
		.den       (dden_s74),
		.side_in   (dside_s74),
		.out_valid (dv_v),
		.quo       (dquo),
		.side_out  (dside_vec)
	);

	rsi_div #(.NW(NW), .FRAC_BITS(FRAC_BITS), .SW(1)) u_div_offset (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s74),
		.num       (onum_s74),
		.den       (oden_s74),
		.side_in   (away_s74),
		.out_valid (ov_v),
		.quo       (oquo),
		.side_out  (oaway)
	);

	assign dside = rsi_pkg::dv_side_t'(dside_vec);

	// output register
	logic done_q, hit_q;
	logic [OW-1:0] dist_q, offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= dside.hit;
		dist_q <= (dside.hit && !dside.qzero) ? dquo : '0;
		offset_q <= oaway[0] ? '0 : oquo;
	end

	assign done = done_q;
	assign hit = hit_q;
	assign hit_distance = dist_q;
	assign offset_ratio = offset_q;

	`RSI_ASSERT_IMPLIES(a_sqrt_lockstep, clk, arst_n, 1'b1, sq_v == sqh_v, "sqrt pipelines out of step")
	`RSI_ASSERT_IMPLIES(a_div_lockstep, clk, arst_n, 1'b1, dv_v == ov_v, "divider pipelines out of step")
	`RSI_ASSERT_IMPLIES(a_latency, clk, arst_n, done, $past(take, LAT), "result without a matching transaction")
	`RSI_ASSERT_NEXT(a_miss_zero, clk, arst_n, dv_v && !dside.hit, hit_distance == '0, "miss with nonzero distance")
endmodule
`default_nettype wire

>>> verif/rsi_checker.sv
`timescale 1ns / 1ps
module rsi_checker #(
	parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic [30:0]        sphere_radius,
	input  logic               done,
	input  logic               hit,
	input  logic [30:0]        hit_distance,
	input  logic [30:0]        offset_ratio,
	output int                 fail_count,
	output int                 pending
);
	typedef struct packed {
		logic        hit;
		logic [30:0] distance;
		logic [30:0] offset;
	} isect_t;

	localparam logic [127:0] CLAMP = 128'h4000_0000_0000_0000;
	localparam logic [127:0] SAT = 128'h7FFF_FFFF;

	isect_t expected_q[$];

	function automatic logic [63:0] root_floor(input logic [127:0] x);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (128'(t) * 128'(t) <= x) r = t;
		end
		return r;
	endfunction

	function automatic logic [30:0] clip31(input logic [127:0] v);
		return (v > SAT) ? 31'h7FFF_FFFF : v[30:0];
	endfunction

	function automatic logic [63:0] absval(input longint x);
		return (x < 0) ? 64'(-x) : 64'(x);
	endfunction

	function automatic isect_t predict_isect(input logic signed [31:0] o[3],
			input logic signed [31:0] dv[3], input logic signed [31:0] c[3],
			input logic [30:0] rad);
		isect_t res;
		longint lv[3];
		longint dl[3];
		longint p;
		longint mv;
		longint v;
		logic [63:0] pos, neg, pmag, asum, lsum, r2, cmag, len;
		logic [127:0] m, a, vsq, p2, ac, hq, q;
		logic cneg;
		res = '0;
		pos = 0;
		neg = 0;
		vsq = 0;
		asum = 0;
		lsum = 0;
		for (int i = 0; i < 3; i++) begin
			lv[i] = longint'(o[i]) - longint'(c[i]);
			if (lv[i] > 64'sd2147483647) lv[i] = 64'sd2147483647;
			if (lv[i] < -64'sd2147483648) lv[i] = -64'sd2147483648;
			dl[i] = longint'(dv[i]);
		end
		for (int i = 0; i < 3; i++) begin
			p = lv[i] * dl[i];
			if (p >= 0) pos += 64'(p);
			else neg += absval(p);
		end
		// ray pointing away from the center
		if (pos > neg) return res;
		pmag = neg - pos;
		for (int i = 0; i < 3; i++) begin
			m = (128'(pmag) * 128'(absval(dl[i]))) >> (2 * FRAC_BITS);
			mv = (m > CLAMP) ? longint'(CLAMP[63:0]) : longint'(m[63:0]);
			v = dl[i] > 0 ? lv[i] + mv : (dl[i] < 0 ? lv[i] - mv : lv[i]);
			a = 128'(absval(v));
			if (a > CLAMP) a = CLAMP;
			vsq = vsq + a * a;
		end
		len = root_floor(vsq);
		res.offset = (rad == 0) ? 31'h7FFF_FFFF :
			clip31((128'(len) << FRAC_BITS) / 128'(rad));
		for (int i = 0; i < 3; i++) begin
			asum += absval(dl[i]) * absval(dl[i]);
			lsum += absval(lv[i]) * absval(lv[i]);
		end
		if (asum == 0) return res;
		r2 = 64'(rad) * 64'(rad);
		cneg = lsum < r2;
		cmag = cneg ? r2 - lsum : lsum - r2;
		p2 = 128'(pmag) * 128'(pmag);
		ac = 128'(asum) * 128'(cmag);
		if (cneg) begin
			hq = p2 + ac;
		end else begin
			if (p2 < ac) return res;
			hq = p2 - ac;
		end
		q = 128'(pmag) + 128'(root_floor(hq));
		res.hit = 1'b1;
		if (cneg) res.distance = clip31((q << FRAC_BITS) / 128'(asum));
		else if (q == 0) res.distance = '0;
		else res.distance = clip31((128'(cmag) << FRAC_BITS) / q);
		return res;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		isect_t want;
		if (!arst_n) begin
			fail_count <= 0;
			expected_q.delete();
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result hit=%0b dist=%0d offset=%0d",
						$time, hit, hit_distance, offset_ratio);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (want.hit !== hit || want.distance !== hit_distance ||
							want.offset !== offset_ratio) begin
						$display("%0t: mismatch expected hit=%0b dist=%0d offset=%0d, actual hit=%0b dist=%0d offset=%0d",
							$time, want.hit, want.distance, want.offset,
							hit, hit_distance, offset_ratio);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(predict_isect('{origin_x, origin_y, origin_z},
					'{dir_x, dir_y, dir_z}, '{center_x, center_y, center_z},
					sphere_radius));
		end
	end
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic signed [31:0] center_x = '0, center_y = '0, center_z = '0;
	logic [30:0]        sphere_radius = 31'd1;
	logic               done;
	logic               hit;
	logic [30:0]        hit_distance;
	logic [30:0]        offset_ratio;
	int                 fail_count;
	int                 pending;
	int                 burst_left = 0;

	localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SMIN = 32'sh8000_0000;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;

	always #6 clk = ~clk;

	ray_sphere_intersect_top DUT (.*);
	rsi_checker checker_i (.*);

	// one ray transaction; gap cycles of idle before it
	task automatic issue_ray(input logic signed [31:0] ox, oy, oz, dx, dy, dz,
			cx, cy, cz, input logic [30:0] rad);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, 12);
			if ($urandom_range(0, 40) == 0) burst_left = $urandom_range(10, 60);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		origin_x <= ox; origin_y <= oy; origin_z <= oz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz;
		center_x <= cx; center_y <= cy; center_z <= cz;
		sphere_radius <= rad;
		start <= 1'b1;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	// random coordinate with random magnitude scale
	function automatic logic signed [31:0] coord();
		logic signed [31:0] v;
		v = $urandom;
		return v >>> $urandom_range(0, 31);
	endfunction

	function automatic logic [30:0] radius_rand();
		logic [30:0] r;
		r = 31'($urandom) >> $urandom_range(0, 30);
		return (r == 0) ? 31'd1 : r;
	endfunction

	initial begin
		logic signed [31:0] ox, oy, oz, dx, dy, dz, k;
		int sh;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: hits, inside sphere, away, zero direction, misses, extremes
		issue_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 0, 0, 31'(2 * ONE));
		issue_ray(0, 0, 0, 0, ONE, 0, 0, 0, 0, 31'(3 * ONE));
		issue_ray(0, 0, 0, -ONE, 0, 0, 10 * ONE, 0, 0, 31'(2 * ONE));
		issue_ray(0, 0, 0, 0, 0, 0, 5 * ONE, 0, 0, 31'(ONE));
		issue_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 5 * ONE, 0, 31'(ONE));
		issue_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, ONE, 0, 31'(ONE));
		issue_ray(0, 0, 0, ONE, ONE, ONE, 4 * ONE, 4 * ONE, 4 * ONE, 31'd1);
		issue_ray(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 31'h7FFF_FFFF);
		issue_ray(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 31'd1);
		issue_ray(SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMAX, SMIN, SMAX, 31'h7FFF_FFFF);
		issue_ray(0, 0, 0, 32'sd1, 0, 0, 32'sd100, 0, 0, 31'd1);
		issue_ray(0, 0, 0, SMAX, 0, 0, SMAX, 0, 0, 31'h7FFF_FFFF);
		issue_ray(-1, -1, -1, -1, -1, -1, SMIN, SMIN, SMIN, 31'h4000_0000);
		issue_ray(0, 0, 0, 0, 0, -ONE, 0, 0, -SMAX, 31'(ONE));
		issue_ray(SMAX, 0, 0, ONE, 0, 0, SMAX, 0, 0, 31'(ONE));
		issue_ray(0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0, 31'(2 * ONE));
		issue_ray(0, 0, 0, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 31'h7FFF_FFFF);
		issue_ray(32'sh5555_5555, 32'shAAAA_AAAA, 0, ONE, -ONE, 0,
			32'shAAAA_AAAA, 32'sh5555_5555, 0, 31'h5555_5555);
		issue_ray(0, 0, 0, ONE, 0, 0, 0, 0, 0, 31'h2AAA_AAAA);
		// let everything drain before the random part
		start <= 1'b0;
		wait (pending == 0);
		for (int n = 0; n < 1300; n++) begin
			if (n == 650) begin
				start <= 1'b0;
				wait (pending == 0);
			end
			if ($urandom_range(0, 9) < 7) begin
				// well formed: center ahead along the ray with small offset
				sh = $urandom_range(4, 20);
				ox = coord() >>> 2; oy = coord() >>> 2; oz = coord() >>> 2;
				dx = 32'($signed($urandom)) >>> (sh + 8);
				dy = 32'($signed($urandom)) >>> (sh + 8);
				dz = 32'($signed($urandom)) >>> (sh + 8);
				k = $urandom_range(0, 64);
				issue_ray(ox, oy, oz, dx, dy, dz,
					ox + dx * k + (coord() >>> 8), oy + dy * k + (coord() >>> 8),
					oz + dz * k + (coord() >>> 8), radius_rand());
			end else begin
				issue_ray(coord(), coord(), coord(), coord(), coord(), coord(),
					coord(), coord(), coord(), radius_rand());
			end
		end
		start <= 1'b0;
		wait (pending == 0);
		repeat (120) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("Verification failed");
		$finish;
	end
endmodule
